[hw/rtl/form_urlencoded_stream_decoder_top_macros.svh]
// Assertion macros shared by the form decoder RTL.
// Needs no other file; the asserting modules include it.
`ifndef FORM_URLENCODED_STREAM_DECODER_TOP_MACROS_SVH
`define FORM_URLENCODED_STREAM_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define FUSD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("fusd assertion failed");
// next-cycle implication, checked out of reset
`define FUSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fusd assertion failed");
`else
`define FUSD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define FUSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/fusd_pkg.sv]
// Shared types, character codes and hex helpers for the form decoder.
// No dependencies.
`default_nettype none
package fusd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_KEY     = 2'd0,
		KIND_VALUE   = 2'd1,
		KIND_COMMIT  = 2'd2,
		KIND_DISCARD = 2'd3
	} kind_t;

	// one queue entry: up to one decoded byte, then up to one pair marker
	typedef struct packed {
		logic       has_byte;
		kind_t      byte_kind;
		logic [7:0] byte_val;
		logic       has_mark;
		kind_t      mark_kind;
	} work_t;

	// {is_hex, digit}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
		logic [4:0] hi;
		logic [4:0] lo;
		logic [7:0] r;
		hi = hex_digit(a);
		lo = hex_digit(b);
		if (!hi[4]) begin
			r = 8'd0;
		end else if (!lo[4]) begin
			r = {4'd0, hi[3:0]};
		end else begin
			r = {hi[3:0], lo[3:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/fusd_front.sv]
// Front end: takes body bytes, tracks segment and escape state, and builds
// at most one queue entry per byte. Depends on fusd_pkg and the macro header.
`default_nettype none
`include "form_urlencoded_stream_decoder_top_macros.svh"
module fusd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_stall,
	input  wire logic [7:0]     body_byte,
	input  wire logic           final_byte,
	output fusd_pkg::work_t     push_data,
	output logic                push
);

	typedef enum logic [2:0] {
		ESC_IDLE = 3'b001,
		ESC_PCT  = 3'b010,
		ESC_HELD = 3'b100
	} esc_t;

	esc_t       esc_q, esc_n;
	logic       in_value_q, in_value_n;
	logic [7:0] held_q, held_n;
	logic       fire, term, pair_end;
	fusd_pkg::work_t w;

	assign fire = in_valid && !in_stall;

	// plain decode of one byte: '+' becomes a space; callers drop a lone '%'
	function automatic logic [7:0] plain_val(input logic [7:0] c);
		return (c == fusd_pkg::CH_PLUS) ? fusd_pkg::CH_SPACE : c;
	endfunction

	always_comb begin
		term       = (body_byte == fusd_pkg::CH_AMP) ||
			((body_byte == fusd_pkg::CH_EQ) && !in_value_q);
		pair_end   = (body_byte == fusd_pkg::CH_AMP) || final_byte;
		esc_n      = ESC_IDLE;
		held_n     = held_q;
		w          = '0;
		w.byte_kind = in_value_q ? fusd_pkg::KIND_VALUE : fusd_pkg::KIND_KEY;
		case (esc_q)
			ESC_HELD: begin
				if (term) begin
					w.has_byte = (held_q != fusd_pkg::CH_PCT);
					w.byte_val = plain_val(held_q);
				end else begin
					w.has_byte = 1'b1;
					w.byte_val = fusd_pkg::hex_pair(held_q, body_byte);
				end
			end
			ESC_PCT: begin
				if (!term) begin
					if (final_byte) begin
						w.has_byte = (body_byte != fusd_pkg::CH_PCT);
						w.byte_val = plain_val(body_byte);
					end else begin
						held_n = body_byte;
						esc_n  = ESC_HELD;
					end
				end
			end
			default: begin
				if (!term) begin
					if (body_byte == fusd_pkg::CH_PCT) begin
						esc_n = ESC_PCT;
					end else begin
						w.has_byte = 1'b1;
						w.byte_val = plain_val(body_byte);
					end
				end
			end
		endcase
		in_value_n = in_value_q || (term && (body_byte == fusd_pkg::CH_EQ));
		if (pair_end) begin
			w.has_mark  = 1'b1;
			w.mark_kind = in_value_n ? fusd_pkg::KIND_COMMIT : fusd_pkg::KIND_DISCARD;
			in_value_n  = 1'b0;
			esc_n       = ESC_IDLE;
			held_n      = 8'd0;
		end
	end

	assign push_data = w;
	assign push      = fire && (w.has_byte || w.has_mark);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q      <= ESC_IDLE;
			in_value_q <= 1'b0;
			held_q     <= 8'd0;
		end else if (fire) begin
			esc_q      <= esc_n;
			in_value_q <= in_value_n;
			held_q     <= held_n;
		end
	end

	// a pair end leaves the front in the key segment with no escape pending
	`FUSD_ASSERT_NEXT(a_pair_end_clears, clk, arst_n, fire && pair_end, (esc_q == ESC_IDLE) && !in_value_q)

endmodule
`default_nettype wire

[hw/rtl/fusd_queue.sv]
// Small flop-based FIFO of work entries between front and back.
// Depends on fusd_pkg and the macro header.
`default_nettype none
`include "form_urlencoded_stream_decoder_top_macros.svh"
module fusd_queue #(
	parameter int DEPTH = fusd_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fusd_pkg::work_t push_data,
	input  wire logic            pop,
	output fusd_pkg::work_t      head,
	output logic                 empty,
	output logic                 full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fusd_pkg::work_t  entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`FUSD_ASSERT_IMPLY(a_no_push_full, clk, arst_n, full, !push)
	`FUSD_ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, empty, !pop)

endmodule
`default_nettype wire

[hw/rtl/fusd_back.sv]
// Back end: drains queue entries into the output register, one result
// per transfer, byte first and pair marker second. Depends on fusd_pkg.
`default_nettype none
`include "form_urlencoded_stream_decoder_top_macros.svh"
module fusd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fusd_pkg::work_t head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [1:0]           item_kind,
	output logic [7:0]           out_byte,
	output logic                 run_end
);

	logic            out_valid_q, run_end_q, second_q;
	fusd_pkg::kind_t kind_q;
	logic [7:0]      byte_q;
	logic            load, take_byte;

	assign load      = !out_valid_q || !out_stall;
	// byte goes out first unless this entry's byte already left
	assign take_byte = head.has_byte && !second_q;
	assign pop       = load && !empty && !(take_byte && head.has_mark);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				second_q <= take_byte && head.has_mark;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (take_byte) begin
				kind_q    <= head.byte_kind;
				byte_q    <= head.byte_val;
				run_end_q <= !head.has_mark;
			end else begin
				kind_q    <= head.mark_kind;
				byte_q    <= 8'd0;
				run_end_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign item_kind = kind_q;
	assign out_byte  = byte_q;
	assign run_end   = run_end_q;

	// a held marker always follows a byte still on the output
	`FUSD_ASSERT_IMPLY(a_second_has_byte, clk, arst_n, second_q, out_valid_q && !run_end_q)

endmodule
`default_nettype wire

[hw/rtl/form_urlencoded_stream_decoder_top.sv]
// Form body (x-www-form-urlencoded) streaming decoder, top level.
// Uses fusd_pkg, fusd_front, fusd_queue and fusd_back.
//
// Input channel: in_valid / in_stall with body_byte and final_byte, one raw
//   body byte per transfer; final_byte marks the last byte of the body.
// Output channel: out_valid / out_stall with item_kind, out_byte, run_end.
//   item_kind: key byte, value byte, pair commit or pair discard. Key and
//   value bytes stream out before the pair is known to hold an '='; the
//   consumer drops bytes of a pair that ends with a discard marker.
//   run_end flags the last result caused by one input byte.
// Path: a byte accepted on the input is written into the queue, and its first
//   result is then loaded from the queue into the output register.
// Throughput: one byte per cycle while in_stall is low. A byte yielding both
//   a decoded byte and a pair marker takes two output transfers; the queue
//   (QUEUE_DEPTH entries) absorbs that, and in_stall rises only on a full queue.
// A byte that yields no result ('%', '=' ending a key, etc.) uses no slot.
// Output stall: the output register holds its result; the queue keeps
//   filling until full, then in_stall is raised.
// Reset (arst_n low, async): queue empty, output invalid, decoder back in
//   the key segment with no escape pending.
`default_nettype none
module form_urlencoded_stream_decoder_top #(
	parameter int QUEUE_DEPTH = fusd_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] body_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      item_kind,
	output logic [7:0]      out_byte,
	output logic            run_end
);

	fusd_pkg::work_t push_data;
	fusd_pkg::work_t head;
	logic            push, pop, q_empty, q_full;

	// stall only on queue occupancy, never on in_valid
	assign in_stall = q_full;

	// front: segment / escape tracking, decode, marker generation
	fusd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.body_byte  (body_byte),
		.final_byte (final_byte),
		.push_data  (push_data),
		.push       (push)
	);

	// decouples front from back so each stalls on its own
	fusd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back: splits each entry into one or two output transfers
	fusd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.item_kind (item_kind),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

endmodule
`default_nettype wire
